### hdl/assert_macros.svh
// Assertion macros shared by the frontier cell detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

### hdl/fcd_pkg.sv
// Types, constants and the cell classifier of the frontier cell detector.
package fcd_pkg;

    localparam int CELL_W     = 8;
    localparam int CFG_W      = 11;
    localparam int OUT_W      = 10;
    localparam int CLS_W      = 2;
    localparam int LINE_W     = 2 * CLS_W;
    localparam int OBUF_DEPTH = 3;

    typedef enum logic [CLS_W-1:0] {
        CLS_FREE    = 2'd0,
        CLS_UNKNOWN = 2'd1,
        CLS_OTHER   = 2'd2
    } cls_t;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
    } frontier_t;

    localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;

    function automatic cls_t classify(input logic [CELL_W-1:0] raw);
        cls_t result;
        if (raw == CELL_FREE) begin
            result = CLS_FREE;
        end else if (raw == CELL_UNKNOWN) begin
            result = CLS_UNKNOWN;
        end else begin
            result = CLS_OTHER;
        end
        return result;
    endfunction

endpackage

### hdl/fcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module fcd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/fcd_window.sv
// Three by three window of cell classes and the frontier test on its center.
module fcd_window (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          check,
    input  fcd_pkg::cls_t top_cls,
    input  fcd_pkg::cls_t mid_cls,
    input  fcd_pkg::cls_t bot_cls,
    output logic          hit
);

    import fcd_pkg::*;

    cls_t win_reg [3][3];
    cls_t col_in [3];
    logic any_unknown;

    assign col_in[0] = top_cls;
    assign col_in[1] = mid_cls;
    assign col_in[2] = bot_cls;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= CLS_UNKNOWN;
                end
            end
        end else if (en) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= col_in[i];
            end
        end
    end

    // The window after this step's shift: the old middle column moves left,
    // the old right column becomes the middle, and the new column enters.
    always_comb begin
        any_unknown = (win_reg[0][2] == CLS_UNKNOWN) || (win_reg[2][2] == CLS_UNKNOWN);
        for (int i = 0; i < 3; i++) begin
            if (win_reg[i][1] == CLS_UNKNOWN || col_in[i] == CLS_UNKNOWN) begin
                any_unknown = 1'b1;
            end
        end
    end

    assign hit = en && check && (win_reg[1][2] == CLS_FREE) && any_unknown;

endmodule

### hdl/fcd_outbuf.sv
// Three-entry result queue that decouples the detector from a stalling receiver.
`include "assert_macros.svh"

module fcd_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fcd_pkg::frontier_t push_data,
    input  logic               reserve,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output fcd_pkg::frontier_t m_data
);

    import fcd_pkg::*;

    frontier_t  entry_reg [OBUF_DEPTH];
    logic [1:0] head_reg;
    logic [1:0] head_next;
    logic [1:0] tail_reg;
    logic [1:0] tail_next;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       pop;

    assign m_valid = (occ_reg != 2'd0);
    assign m_data  = entry_reg[head_reg];
    assign pop     = m_valid && m_ready;

    // Space is counted for a request still in the detect stage.
    assign room = (({1'b0, occ_reg} + 3'(reserve)) < 3'(OBUF_DEPTH));

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (pop) begin
            head_next = (head_reg == 2'(OBUF_DEPTH - 1)) ? 2'd0 : head_reg + 2'd1;
        end
        if (push) begin
            tail_next = (tail_reg == 2'(OBUF_DEPTH - 1)) ? 2'd0 : tail_reg + 2'd1;
        end
        if (push && !pop) begin
            occ_next = occ_reg + 2'd1;
        end else if (pop && !push) begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 2'd0;
            tail_reg <= 2'd0;
            occ_reg  <= 2'd0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_push_when_full, aclk, aresetn, push && !pop && occ_reg == 2'(OBUF_DEPTH), "result queue overflow")
    `ASSERT_CLK(a_occ_bound, aclk, aresetn, occ_reg <= 2'(OBUF_DEPTH), "result queue count out of range")

endmodule

### hdl/frontier_cell_detector.sv
// Frontier cell detector: raster-order occupancy cells in, frontier positions out.
//
// Cells arrive on the s_ channel, one signed occupancy byte per request, in
// raster order; s_start_of_map marks the first cell of a grid and zeroes the
// row and column counters. A free interior cell with an unknown neighbor among
// its eight is reported on the m_ channel as its row and column, in raster
// order, once its lower-right neighbor has been taken.
// The block takes one cell per clock while s_ready is high. A hit from the detect
// stage register is written to the result queue, which raises m_valid. The line
// store RAM is read in the accept cycle and written back in the next; a
// back-to-back request to the same column is served from a forwarding register.
// Reset zeroes the counters, sets the window to the unknown class, sets the
// map size to 1024 by 1024 and empties the result queue. The line store is not
// cleared: it holds the two previous rows, so it is filled by the grid itself.
// When m_ready is low, results wait in a three-entry queue and s_ready drops
// only when that queue and the detect stage could not absorb another result.
// map_width and map_height must be written on the cfg port only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module frontier_cell_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [fcd_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [fcd_pkg::CELL_W-1:0] s_cell_value,
    input  logic                            s_start_of_map,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fcd_pkg::OUT_W-1:0]       m_frontier_row,
    output logic [fcd_pkg::OUT_W-1:0]       m_frontier_col
);

    import fcd_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSW = $clog2(MAX_WIDTH + 1);
    localparam int HSW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0]  map_width_reg;
    logic [CFG_W-1:0]  map_height_reg;
    logic [WSW-1:0]    w_eff;
    logic [HSW-1:0]    h_eff;

    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic [CW-1:0]     c_cur;
    logic [RW-1:0]     r_cur;
    logic              last_col;
    logic              last_row;
    logic              interior;
    logic              accept;

    logic              s1_valid_reg;
    cls_t              cls_reg;
    logic [CW-1:0]     col_s1_reg;
    logic              check_reg;
    frontier_t         pos_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] line_wdata;
    cls_t              above2;
    cls_t              above1;
    logic              hit;
    logic              room;
    frontier_t         m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= CFG_W'(1024);
            map_height_reg <= CFG_W'(1024);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (map_width_reg == '0) begin
            w_eff = WSW'(1);
        end else if (32'(map_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WSW'(MAX_WIDTH);
        end else begin
            w_eff = WSW'(map_width_reg);
        end
        if (map_height_reg == '0) begin
            h_eff = HSW'(1);
        end else if (32'(map_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HSW'(MAX_HEIGHT);
        end else begin
            h_eff = HSW'(map_height_reg);
        end
    end

    assign accept = s_valid && s_ready;
    assign c_cur  = s_start_of_map ? '0 : col_reg;
    assign r_cur  = s_start_of_map ? '0 : row_reg;

    assign last_col = (32'(c_cur) + 32'd1) >= 32'(w_eff);
    assign last_row = (32'(r_cur) + 32'd1) >= 32'(h_eff);
    assign interior = (32'(r_cur) >= 32'd2) && (32'(c_cur) >= 32'd2)
                   && (32'(r_cur) < 32'(h_eff)) && (32'(c_cur) < 32'(w_eff));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : r_cur + RW'(1);
            end else begin
                col_next = c_cur + CW'(1);
                row_next = r_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            fwd_reg      <= accept && s1_valid_reg && (col_s1_reg == c_cur);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= line_wdata;
        if (accept) begin
            cls_reg     <= classify(s_cell_value);
            col_s1_reg  <= c_cur;
            check_reg   <= interior;
            pos_reg.row <= OUT_W'(r_cur - RW'(1));
            pos_reg.col <= OUT_W'(c_cur - CW'(1));
        end
    end

    assign line       = fwd_reg ? fwd_data_reg : ram_rdata;
    assign above2     = cls_t'(line[LINE_W-1:CLS_W]);
    assign above1     = cls_t'(line[CLS_W-1:0]);
    assign line_wdata = {above1, cls_reg};

    fcd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (col_s1_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    fcd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (s1_valid_reg),
        .check   (check_reg),
        .top_cls (above2),
        .mid_cls (above1),
        .bot_cls (cls_reg),
        .hit     (hit)
    );

    fcd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (hit),
        .push_data (pos_reg),
        .reserve   (s1_valid_reg),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign s_ready        = room;
    assign m_frontier_row = m_data.row;
    assign m_frontier_col = m_data.col;

    `ASSERT_CLK(a_fwd_needs_stage, aclk, aresetn, fwd_reg |-> s1_valid_reg, "forwarding without a request in the detect stage")
    `ASSERT_CLK(a_accept_fills_stage, aclk, aresetn, accept |=> s1_valid_reg, "accepted request did not reach the detect stage")
    `ASSERT_NEVER(a_hit_outside_interior, aclk, aresetn, hit && !check_reg, "frontier reported for a border cell")

endmodule

### verif/frontier_cell_detector_checker.sv
// Checker for the frontier cell detector: predicts frontier positions and compares results.
module frontier_cell_detector_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [fcd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [fcd_pkg::CELL_W-1:0] s_cell_value,
    input  logic                              s_start_of_map,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [fcd_pkg::OUT_W-1:0]         m_frontier_row,
    input  logic [fcd_pkg::OUT_W-1:0]         m_frontier_col,
    output int                                errors,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcd_pkg::*;

    cls_t             older_row [MAX_WIDTH];
    cls_t             newer_row [MAX_WIDTH];
    cls_t             window [3][3];
    int unsigned      next_row;
    int unsigned      next_col;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    frontier_t        expected_frontiers [$];
    int               error_count   = 0;
    int               pending_count = 0;

    assign errors  = error_count;
    assign pending = pending_count;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned top);
        if (v == '0) begin
            return 1;
        end
        if (32'(v) > top) begin
            return top;
        end
        return 32'(v);
    endfunction

    function automatic cls_t cell_class(input logic signed [CELL_W-1:0] v);
        if (v == '0) begin
            return CLS_FREE;
        end
        if (v == '1) begin
            return CLS_UNKNOWN;
        end
        return CLS_OTHER;
    endfunction

    task automatic take_cell(input logic signed [CELL_W-1:0] v, input logic sof);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        cls_t        cls;
        cls_t        up2;
        cls_t        up1;
        logic        saw_unknown;
        frontier_t   hit;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (sof) begin
            next_row = 0;
            next_col = 0;
        end
        r   = next_row;
        c   = next_col;
        cls = cell_class(v);
        up2 = older_row[c];
        up1 = newer_row[c];
        older_row[c] = up1;
        newer_row[c] = cls;
        for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = up2;
        window[1][2] = up1;
        window[2][2] = cls;
        if (r >= 2 && c >= 2 && r < h && c < w) begin
            saw_unknown = 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (!(i == 1 && j == 1) && window[i][j] == CLS_UNKNOWN) begin
                        saw_unknown = 1'b1;
                    end
                end
            end
            if (window[1][1] == CLS_FREE && saw_unknown) begin
                hit.row = OUT_W'(r - 1);
                hit.col = OUT_W'(c - 1);
                expected_frontiers.insert(expected_frontiers.size(), hit);
            end
        end
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endtask

    task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: frontier %s mismatch, expected %0d, got %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        frontier_t want;
        if (!aresetn) begin
            foreach (older_row[k]) begin
                older_row[k] = CLS_FREE;
                newer_row[k] = CLS_FREE;
            end
            foreach (window[i, j]) begin
                window[i][j] = CLS_UNKNOWN;
            end
            next_row   = 0;
            next_col   = 0;
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            expected_frontiers.delete();
        end else begin
            if (s_valid && s_ready) begin
                take_cell(s_cell_value, s_start_of_map);
            end
            if (cfg_wr_en) begin
                if (cfg_idx_t'(cfg_index) == REG_MAP_WIDTH) begin
                    width_reg = cfg_data;
                end else begin
                    height_reg = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_frontiers.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected frontier, expected none, got row %0d col %0d",
                             $time, m_frontier_row, m_frontier_col);
                end else begin
                    want = expected_frontiers.pop_front();
                    compare_field("row", want.row, m_frontier_row);
                    compare_field("col", want.col, m_frontier_col);
                end
            end
        end
        pending_count = expected_frontiers.size();
    end

endmodule

### verif/frontier_cell_detector_test.sv
// Testbench top for the frontier cell detector: clock, reset, cell stimulus and verdict.
module frontier_cell_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcd_pkg::*;

    localparam int STALL_CYCLES = 400;

    localparam logic signed [CELL_W-1:0] SAMPLE_GRID [16] = '{
        8'shFF, 8'sh00, 8'sh00, 8'sh00,
        8'sh00, 8'sh00, 8'sh00, 8'sh7F,
        8'sh00, 8'sh00, 8'sh00, 8'sh00,
        8'sh80, 8'sh00, 8'sh00, 8'shFF
    };

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_wr_en      = 1'b0;
    logic                     cfg_index      = 1'b0;
    logic [CFG_W-1:0]         cfg_data       = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [CELL_W-1:0] s_cell_value   = '0;
    logic                     s_start_of_map = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [OUT_W-1:0]         m_frontier_row;
    logic [OUT_W-1:0]         m_frontier_col;
    int                       errors;
    int                       pending;

    int          sender_max_gap = 10;
    int          sink_max_gap   = 10;
    logic        stall_request  = 1'b0;
    int          cells_sent     = 0;
    int unsigned width_eff      = 1024;
    int unsigned height_eff     = 1024;
    logic        need_start     = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    frontier_cell_detector u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_value   (s_cell_value),
        .s_start_of_map (s_start_of_map),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frontier_row (m_frontier_row),
        .m_frontier_col (m_frontier_col)
    );

    frontier_cell_detector_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_value   (s_cell_value),
        .s_start_of_map (s_start_of_map),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frontier_row (m_frontier_row),
        .m_frontier_col (m_frontier_col),
        .errors         (errors),
        .pending        (pending)
    );

    task automatic send_cell(input logic signed [CELL_W-1:0] v, input logic sof);
        int gap;
        gap = int'($urandom_range(0, sender_max_gap));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cell_value   <= v;
        s_start_of_map <= sof;
        do @(posedge aclk); while (!s_ready);
        cells_sent++;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        int unsigned new_width;
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data  <= w;
        @(negedge aclk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data  <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        new_width  = (w == '0) ? 1 : (32'(w) > 1024) ? 1024 : 32'(w);
        height_eff = (h == '0) ? 1 : (32'(h) > 1024) ? 1024 : 32'(h);
        // Widening mid-grid would read line store columns this grid never wrote.
        need_start = need_start || (new_width > width_eff);
        width_eff  = new_width;
    endtask

    function automatic logic signed [CELL_W-1:0] random_cell(input int unknown_pct);
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < unknown_pct) begin
            return '1;
        end
        if (pick < unknown_pct + 45) begin
            return '0;
        end
        return CELL_W'($urandom_range(0, 255));
    endfunction

    task automatic send_stream(input int count, input int unknown_pct);
        logic sof;
        for (int k = 0; k < count; k++) begin
            sof = (k == 0 && (need_start || $urandom_range(0, 1) == 0))
                  || $urandom_range(0, 49) == 0;
            need_start = 1'b0;
            send_cell(random_cell(unknown_pct), sof);
        end
    endtask

    task automatic random_phase();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int               count;
        int               pct;
        if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
                0:       w = CFG_W'($urandom_range(0, 2));
                1:       w = CFG_W'($urandom_range(9, 24));
                default: w = CFG_W'($urandom_range(3, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       h = CFG_W'($urandom_range(0, 2));
                1:       h = CFG_W'($urandom_range(1024, 2047));
                default: h = CFG_W'($urandom_range(3, 8));
            endcase
            configure(w, h);
        end
        sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
        sink_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 10;
        if (width_eff * height_eff > 100) begin
            count = int'($urandom_range(20, 80));
        end else begin
            count = int'(width_eff * height_eff * $urandom_range(1, 2));
        end
        if ($urandom_range(0, 6) == 0) begin
            count = int'($urandom_range(1, count));
        end
        case ($urandom_range(0, 2))
            0:       pct = 5;
            1:       pct = 20;
            default: pct = 40;
        endcase
        send_stream(count, pct);
    endtask

    initial begin : result_sink
        int hold;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            hold = int'($urandom_range(0, sink_max_gap));
            if (stall_request) begin
                hold          = STALL_CYCLES;
                stall_request = 1'b0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int base;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_cell(8'sh80, 1'b0);
        send_cell(8'sh7F, 1'b0);
        send_cell(8'sh01, 1'b1);
        configure(11'd0, 11'd0);
        send_cell(8'sh00, 1'b1);
        send_cell(8'shFF, 1'b0);
        configure(11'd4, 11'd4);
        foreach (SAMPLE_GRID[k]) begin
            send_cell(SAMPLE_GRID[k], k == 0);
        end

        while (cells_sent < 150) begin
            random_phase();
        end

        // Dense small grids with the sink held off so the result queue fills.
        configure(11'd6, 11'd6);
        sender_max_gap = 0;
        sink_max_gap   = 10;
        need_start     = 1'b1;
        stall_request  = 1'b1;
        send_stream(108, 30);

        // An oversized width is held to the maximum, so the first row never wraps.
        configure(11'd2047, 11'd3);
        need_start = 1'b1;
        send_stream(60, 20);

        base = cells_sent;
        while (cells_sent < base + 130) begin
            random_phase();
        end

        settle();
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
